// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the event queue modules
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every rising clock edge outside reset
`define TSEQ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define TSEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define TSEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TSEQ_ASSERT(lbl, clk, rstn, prop, msg)
`define TSEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TSEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/core/tseq_pkg.sv -----
// types, codes and constants of the timestamp sorted event queue
// no dependencies
package tseq_pkg;

	// default number of held events
	localparam int TSEQ_DEPTH = 256;
	// width of the reported occupancy
	localparam int OCC_W = 9;

	// input word
	typedef struct packed {
		logic        action;
		logic [31:0] event_timestamp;
		logic [7:0]  device_kind;
		logic [6:0]  device_number;
		logic [7:0]  gadget_kind;
		logic [31:0] event_value;
	} tseq_in_t;

	// action codes
	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_DEQUEUED = 2'd2,
		ST_EMPTY    = 2'd3
	} tseq_status_t;

	// result word
	typedef struct packed {
		tseq_status_t      status;
		logic [31:0]       out_timestamp;
		logic [7:0]        out_device_kind;
		logic [6:0]        out_device_number;
		logic [7:0]        out_gadget_kind;
		logic [31:0]       out_event_value;
		logic [OCC_W-1:0]  occupancy;
	} tseq_out_t;

	// one stored entry: sort key and opaque payload
	typedef struct packed {
		logic [31:0] key;
		logic [7:0]  device_kind;
		logic [6:0]  device_number;
		logic [7:0]  gadget_kind;
		logic [31:0] event_value;
	} tseq_entry_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DEQ,
		S_DONE
	} tseq_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic walk_step;
		logic walk_done;
		logic deq_done;
		logic load_out;
	} tseq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic req_deq;
		logic full;
		logic empty;
		logic shift;
	} tseq_sts_t;

endpackage

// ----- rtl/core/timestamp_sorted_event_queue_top.sv -----
// Timestamp sorted event queue, insertion sorted ring of DEPTH events.
// Enqueue: the walk moves each entry with a greater key up one slot, one ram read
// and write per cycle, then writes the new entry. Dequeue reads the head entry.
// Dropped enqueue/empty dequeue skip both; input stalls until the result is loaded.
// Reset (async, active low) empties the ring; entry ram contents are not cleared.
module timestamp_sorted_event_queue_top #(
	parameter int DEPTH = tseq_pkg::TSEQ_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_stall,
	input  tseq_pkg::tseq_in_t  evt,
	output logic                res_valid,
	input  logic                res_stall,
	output tseq_pkg::tseq_out_t res
);

	import tseq_pkg::*;

	tseq_cmd_t cmd;
	tseq_sts_t sts;

	// sequencing
	tseq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and result words
	tseq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ----- rtl/core/tseq_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
module tseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/tseq_ctrl.sv -----
// controller state machine of the event queue: handshakes and sequencing
// depends on tseq_pkg and assert_macros.svh
`include "assert_macros.svh"

module tseq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_stall,
	output logic                res_valid,
	input  logic                res_stall,
	input  tseq_pkg::tseq_sts_t sts,
	output tseq_pkg::tseq_cmd_t cmd
);

	import tseq_pkg::*;

	tseq_state_t state_q, state_nxt;
	logic        res_valid_q;
	logic        accept;
	logic        out_free;

	assign accept    = evt_valid && (state_q == S_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign evt_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (sts.req_deq) begin
						state_nxt = sts.empty ? S_DONE : S_DEQ;
					end else begin
						state_nxt = sts.full ? S_DONE : S_WALK;
					end
				end
			end
			S_WALK: begin
				state_nxt = sts.shift ? S_WALK : S_DONE;
			end
			S_DEQ: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				state_nxt = out_free ? S_IDLE : S_DONE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = accept;
			end
			S_WALK: begin
				cmd.walk_step = sts.shift;
				cmd.walk_done = !sts.shift;
			end
			S_DEQ: begin
				cmd.deq_done = 1'b1;
			end
			S_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	`TSEQ_ASSERT(a_cmd_onehot, clk, arst_n, $onehot0(cmd), "more than one datapath command")
	`TSEQ_ASSERT_NXT(a_load_sets_valid, clk, arst_n, cmd.load_out, res_valid, "loaded result not valid")
	`TSEQ_ASSERT_NXT(a_capture_busy, clk, arst_n, cmd.capture, evt_stall, "accepted word did not stall input")
	`TSEQ_ASSERT_NXT(a_deq_finishes, clk, arst_n, cmd.deq_done, state_q == S_DONE, "dequeue did not finish")

endmodule

// ----- rtl/core/tseq_dp.sv -----
// datapath of the event queue: ring indices, count, entry ram and result words
// depends on tseq_pkg, tseq_ram and assert_macros.svh
`include "assert_macros.svh"

module tseq_dp #(
	parameter int DEPTH = tseq_pkg::TSEQ_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tseq_pkg::tseq_in_t  evt,
	output tseq_pkg::tseq_out_t res,
	input  tseq_pkg::tseq_cmd_t cmd,
	output tseq_pkg::tseq_sts_t sts
);

	import tseq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = $bits(tseq_entry_t);

	// ring neighbors
	function automatic logic [AW-1:0] slot_before(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot_after(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [AW-1:0] wr_idx_q, rd_idx_q;
	logic [CW-1:0] count_q, cnt_inc, cnt_dec;
	logic [AW-1:0] dest_q, prev_q;
	tseq_in_t      item_q;
	tseq_out_t     result_q, res_q, res_next;
	logic          res_load;
	logic          full, empty;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	tseq_entry_t   rd_entry, new_entry;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign cnt_inc = count_q + 1'b1;
	assign cnt_dec = count_q - 1'b1;

	assign rd_entry  = ram_rdata;
	assign new_entry = '{
		key:           item_q.event_timestamp,
		device_kind:   item_q.device_kind,
		device_number: item_q.device_number,
		gadget_kind:   item_q.gadget_kind,
		event_value:   item_q.event_value
	};

	// status to controller; held entry moves up while its key is strictly greater
	assign sts.req_deq = (evt.action == ACT_DEQUEUE);
	assign sts.full    = full;
	assign sts.empty   = empty;
	assign sts.shift   = (dest_q != rd_idx_q) && (item_q.event_timestamp < rd_entry.key);

	// ram access: read head or the entry below the write end, then walk down
	always_comb begin
		if (cmd.capture) begin
			ram_raddr = (evt.action == ACT_DEQUEUE) ? rd_idx_q : slot_before(wr_idx_q);
		end else begin
			ram_raddr = slot_before(prev_q);
		end
		ram_we    = cmd.walk_step || cmd.walk_done;
		ram_wdata = cmd.walk_step ? ram_rdata : new_entry;
	end

	tseq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dest_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result of the finished operation
	always_comb begin
		res_next = '0;
		res_load = 1'b0;
		if (cmd.capture) begin
			res_load           = (evt.action == ACT_DEQUEUE) ? empty : full;
			res_next.status    = (evt.action == ACT_DEQUEUE) ? ST_EMPTY : ST_DROPPED;
			res_next.occupancy = OCC_W'(count_q);
		end else if (cmd.walk_done) begin
			res_load           = 1'b1;
			res_next.status    = ST_ENQUEUED;
			res_next.occupancy = OCC_W'(cnt_inc);
		end else if (cmd.deq_done) begin
			res_load                   = 1'b1;
			res_next.status            = ST_DEQUEUED;
			res_next.out_timestamp     = rd_entry.key;
			res_next.out_device_kind   = rd_entry.device_kind;
			res_next.out_device_number = rd_entry.device_number;
			res_next.out_gadget_kind   = rd_entry.gadget_kind;
			res_next.out_event_value   = rd_entry.event_value;
			res_next.occupancy         = OCC_W'(cnt_dec);
		end
	end

	// ring indices and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else if (cmd.walk_done) begin
			wr_idx_q <= slot_after(wr_idx_q);
			count_q  <= cnt_inc;
		end else if (cmd.deq_done) begin
			rd_idx_q <= slot_after(rd_idx_q);
			count_q  <= cnt_dec;
		end
	end

	// captured word and walk pointers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= evt;
			dest_q <= wr_idx_q;
			prev_q <= slot_before(wr_idx_q);
		end else if (cmd.walk_step) begin
			dest_q <= prev_q;
			prev_q <= slot_before(prev_q);
		end
	end

	// result and output registers
	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res_next;
		end
		if (cmd.load_out) begin
			res_q <= result_q;
		end
	end

	assign res = res_q;

	`TSEQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "count beyond depth")
	`TSEQ_ASSERT_IMP(a_deq_not_empty, clk, arst_n, cmd.deq_done, !empty, "dequeue from empty ring")
	`TSEQ_ASSERT_IMP(a_walk_not_full, clk, arst_n, cmd.walk_step || cmd.walk_done, !full, "insert into full ring")
	`TSEQ_ASSERT_NXT(a_enq_counts, clk, arst_n, cmd.walk_done, count_q == $past(cnt_inc), "enqueue count slip")

endmodule
